// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file ptae_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("port assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("port assertion failed");

`endif

// ===== src/ptae_pkg.sv =====
`default_nettype none
package ptae_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_TRANSLATE,
      OP_MULTIPLY,
      OP_DIVIDE,
      OP_ROTATE,
      OP_AREA,
      OP_READ
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_BAD,
      ST_ZERO
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_CORDIC,
      S_READ,
      S_LOAD,
      S_CALC,
      S_WRITE,
      S_ABS,
      S_ROUND,
      S_RESP
   } state_type;

   localparam int CORDIC_STEPS = 30;
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sh026DD3B6A;
   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic [31:0] atan_lut(input logic [4:0] i);
      logic [31:0] v;
      unique case (i)
         5'd0: v = 32'h3243F6A8;
         5'd1: v = 32'h1DAC6705;
         5'd2: v = 32'h0FADBAFC;
         5'd3: v = 32'h07F56EA6;
         5'd4: v = 32'h03FEAB76;
         5'd5: v = 32'h01FFD55B;
         5'd6: v = 32'h00FFFAAA;
         5'd7: v = 32'h007FFF55;
         5'd8: v = 32'h003FFFEA;
         5'd9: v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   // Clamp a signed value to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic signed [79:0] v);
      logic [31:0] r;
      if (v > 80'sd2147483647) begin
         r = 32'h7FFFFFFF;
      end else if (v < -80'sd2147483648) begin
         r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/polygon_transform_area_engine.sv =====
`default_nettype none
// Polygon store of up to MAX_VERTICES Q16.16 vertices in one single-port-read
// synchronous memory, with one operation per request and one response per
// request. Whole-polygon operations walk the store one vertex at a time
// through a single 32x34 multiplier and the memory's one read and one write
// port; rotate first reduces the angle and runs the CORDIC, and divide uses
// a divider that delivers one quotient bit per cycle. The memory is not
// cleared at reset; only entries below the vertex count are ever used in a
// result. A response that waits in the output register does not block the
// next request from entering.
module polygon_transform_area_engine
   import ptae_pkg::*;
#(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_operation,
   input  wire logic signed [31:0] req_x_value,
   input  wire logic signed [31:0] req_y_value,
   input  wire logic signed [31:0] req_factor,
   input  wire logic signed [31:0] req_angle,
   input  wire logic [5:0]         req_vertex_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic [62:0]             rsp_area,
   output logic [6:0]              rsp_count,
   output logic [1:0]              rsp_status
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int SW = AW + 67;

   logic [63:0] mem [MAX_VERTICES];

   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   status_type stat_ff, stat_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0]    ph_ff, ph_in;
   logic          first_ok_ff, first_ok_in;
   logic          flip_ff, flip_in;
   logic [4:0]    ci_ff, ci_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [35:0] cz_ff, cz_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in, f_ff, f_in;
   logic signed [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in, fx_ff, fx_in, fy_ff, fy_in;
   logic [31:0]   res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic signed [SW-1:0] acc_ff, acc_in;
   logic [SW-1:0] mag_ff, mag_in;
   logic [62:0]   area_ff, area_in;
   logic signed [65:0] mul_ff;
   logic [63:0]   rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [62:0]   rsp_area_ff, rsp_area_in;
   logic [6:0]    rsp_count_ff, rsp_count_in;
   status_type    rsp_stat_ff, rsp_stat_in;

   logic signed [31:0] mul_a;
   logic signed [33:0] mul_b;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [63:0]   wr_data;

   logic          div_start, div_done;
   logic [47:0]   div_dividend, div_quo;
   logic [31:0]   div_vmag, div_fmag;
   logic signed [31:0] div_v;
   logic          div_neg;
   logic [31:0]   div_res;

   op_type        req_op;
   logic          zero_f, whole, bad_idx, cnt_zero, cnt_full, cnt_one;
   logic          idx_last, idx_next2_last, slot_free, z_in_range;
   logic signed [33:0] cx_sh, cy_sh, c_nx, c_ny;
   logic signed [35:0] c_nz, c_atan;
   logic signed [65:0] m16;
   logic signed [66:0] r30;
   logic [SW:0]   rsum;
   logic [127:0]  rsh;
   logic [CW+6:0] cnt_ext;

   ptae_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_fmag),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Shared conditions.
   always_comb begin
      req_op   = op_type'(req_operation);
      zero_f   = (req_op == OP_MULTIPLY || req_op == OP_DIVIDE) && req_factor == 32'sd0;
      whole    = req_op == OP_TRANSLATE || req_op == OP_MULTIPLY || req_op == OP_DIVIDE ||
                 req_op == OP_ROTATE || req_op == OP_AREA;
      cnt_zero = count_ff == '0;
      cnt_one  = 32'(count_ff) == 32'd1;
      cnt_full = 32'(count_ff) >= 32'(MAX_VERTICES);
      bad_idx  = 32'(req_vertex_index) >= 32'(count_ff);
      idx_last       = 32'(idx_ff) + 32'd1 == 32'(count_ff);
      idx_next2_last = 32'(idx_ff) + 32'd2 == 32'(count_ff);
      slot_free  = !rsp_valid_ff || !rsp_stall;
      z_in_range = !(cz_ff > PI_Q30) && !(cz_ff <= -PI_Q30);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (zero_f || (whole && cnt_zero)) begin
                  state_in = S_RESP;
               end else begin
                  unique case (req_op)
                     OP_CLEAR, OP_APPEND: state_in = S_RESP;
                     OP_READ:             state_in = bad_idx ? S_RESP : S_LOAD;
                     OP_ROTATE:           state_in = S_REDUCE;
                     default:             state_in = S_READ;
                  endcase
               end
            end
         end
         S_REDUCE: if (z_in_range) state_in = S_CORDIC;
         S_CORDIC: if (ci_ff == 5'(CORDIC_STEPS - 1)) state_in = S_READ;
         S_READ:   state_in = S_LOAD;
         S_LOAD: begin
            priority if (op_ff == OP_READ) begin
               state_in = S_RESP;
            end else if (op_ff == OP_TRANSLATE) begin
               state_in = S_WRITE;
            end else if (op_ff == OP_AREA && !first_ok_ff && !cnt_one) begin
               state_in = S_READ;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            unique case (op_ff)
               OP_MULTIPLY: if (ph_ff == 3'd2) state_in = S_WRITE;
               OP_ROTATE:   if (ph_ff == 3'd5) state_in = S_WRITE;
               OP_DIVIDE:   if (ph_ff == 3'd3 && div_done) state_in = S_WRITE;
               OP_AREA: begin
                  if (ph_ff == 3'd2) begin
                     priority if (idx_last) state_in = S_ABS;
                     else if (!idx_next2_last) state_in = S_READ;
                     else state_in = S_CALC;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_WRITE: state_in = idx_last ? S_RESP : S_READ;
         S_ABS:   state_in = S_ROUND;
         S_ROUND: state_in = S_RESP;
         S_RESP:  if (slot_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      op_in       = op_ff;
      stat_in     = stat_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      ph_in       = ph_ff;
      first_ok_in = first_ok_ff;
      flip_in     = flip_ff;
      ci_in       = ci_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cz_in       = cz_ff;
      tx_in       = tx_ff;
      ty_in       = ty_ff;
      f_in        = f_ff;
      vx_in       = vx_ff;
      vy_in       = vy_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      fx_in       = fx_ff;
      fy_in       = fy_ff;
      res_x_in    = res_x_ff;
      res_y_in    = res_y_ff;
      acc_in      = acc_ff;
      mag_in      = mag_ff;
      area_in     = area_ff;
      mul_a       = vx_ff;
      mul_b       = 34'(f_ff);
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = {res_x_ff, res_y_ff};
      div_start   = 1'b0;

      rd_addr = (op_ff == OP_AREA && first_ok_ff) ? AW'(32'(idx_ff) + 32'd1) : idx_ff;
      if (state_ff == S_IDLE) begin
         rd_addr = AW'(32'(req_vertex_index));
      end

      div_v        = (ph_ff < 3'd2) ? vx_ff : vy_ff;
      div_vmag     = div_v[31] ? ~div_v + 32'd1 : div_v;
      div_fmag     = f_ff[31] ? ~f_ff + 32'd1 : f_ff;
      div_neg      = div_v[31] ^ f_ff[31];
      div_dividend = {div_vmag, 16'd0} + 48'(div_fmag >> 1);
      if (div_neg) begin
         div_res = (div_quo > 48'h80000000) ? 32'h80000000 : ~div_quo[31:0] + 32'd1;
      end else begin
         div_res = (div_quo > 48'h7FFFFFFF) ? 32'h7FFFFFFF : div_quo[31:0];
      end

      cx_sh  = cx_ff >>> ci_ff;
      cy_sh  = cy_ff >>> ci_ff;
      c_atan = 36'(atan_lut(ci_ff));
      if (!cz_ff[35]) begin
         c_nx = cx_ff - cy_sh;
         c_ny = cy_ff + cx_sh;
         c_nz = cz_ff - c_atan;
      end else begin
         c_nx = cx_ff + cy_sh;
         c_ny = cy_ff - cx_sh;
         c_nz = cz_ff + c_atan;
      end

      m16  = (mul_ff + 66'sd32768) >>> 16;
      r30  = ($signed(acc_ff[66:0]) + 67'sd536870912) >>> 30;
      rsum = {1'b0, mag_ff} + (SW + 1)'(32'h10000);
      rsh  = 128'(rsum) >> 17;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req_op;
               tx_in       = req_x_value;
               ty_in       = req_y_value;
               f_in        = req_factor;
               idx_in      = '0;
               ph_in       = '0;
               first_ok_in = 1'b0;
               acc_in      = '0;
               area_in     = '0;
               flip_in     = 1'b0;
               ci_in       = '0;
               cx_in       = CORDIC_GAIN_INV;
               cy_in       = '0;
               cz_in       = {{2{req_angle[31]}}, req_angle, 2'b00};
               stat_in     = ST_OK;
               if (zero_f) begin
                  stat_in = ST_ZERO;
               end else if (whole && cnt_zero) begin
                  stat_in = ST_EMPTY;
               end else if (req_op == OP_CLEAR) begin
                  count_in = '0;
               end else if (req_op == OP_APPEND) begin
                  if (cnt_full) begin
                     stat_in = ST_BAD;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = AW'(count_ff);
                     wr_data  = {req_x_value, req_y_value};
                     count_in = CW'(32'(count_ff) + 32'd1);
                  end
               end else if (req_op == OP_READ && bad_idx) begin
                  stat_in = ST_BAD;
               end
            end
         end
         S_REDUCE: begin
            // The angle is brought into (-pi, pi] by steps of 2*pi, then it is
            // folded into [-pi/2, pi/2] and the result is negated at the end.
            priority if (cz_ff > PI_Q30) begin
               cz_in = cz_ff - TWO_PI_Q30;
            end else if (cz_ff <= -PI_Q30) begin
               cz_in = cz_ff + TWO_PI_Q30;
            end else if (cz_ff > HALF_PI_Q30) begin
               cz_in   = cz_ff - PI_Q30;
               flip_in = 1'b1;
            end else if (cz_ff < -HALF_PI_Q30) begin
               cz_in   = cz_ff + PI_Q30;
               flip_in = 1'b1;
            end else begin
               cz_in = cz_ff;
            end
         end
         S_CORDIC: begin
            cx_in = c_nx;
            cy_in = c_ny;
            cz_in = c_nz;
            ci_in = ci_ff + 5'd1;
            if (ci_ff == 5'(CORDIC_STEPS - 1) && flip_ff) begin
               cx_in = -c_nx;
               cy_in = -c_ny;
            end
         end
         S_READ: begin
         end
         S_LOAD: begin
            ph_in = '0;
            unique case (op_ff)
               OP_READ: begin
                  res_x_in = rd_ff[63:32];
                  res_y_in = rd_ff[31:0];
               end
               OP_TRANSLATE: begin
                  res_x_in = sat32(80'($signed(rd_ff[63:32])) + 80'(tx_ff));
                  res_y_in = sat32(80'($signed(rd_ff[31:0])) + 80'(ty_ff));
               end
               OP_AREA: begin
                  if (!first_ok_ff) begin
                     vx_in       = $signed(rd_ff[63:32]);
                     vy_in       = $signed(rd_ff[31:0]);
                     fx_in       = $signed(rd_ff[63:32]);
                     fy_in       = $signed(rd_ff[31:0]);
                     first_ok_in = 1'b1;
                  end
                  nx_in = $signed(rd_ff[63:32]);
                  ny_in = $signed(rd_ff[31:0]);
               end
               default: begin
                  vx_in = $signed(rd_ff[63:32]);
                  vy_in = $signed(rd_ff[31:0]);
               end
            endcase
         end
         S_CALC: begin
            ph_in = ph_ff + 3'd1;
            unique case (op_ff)
               OP_MULTIPLY: begin
                  if (ph_ff == 3'd1) begin
                     res_x_in = sat32(80'(m16));
                     mul_a    = vy_ff;
                  end
                  if (ph_ff == 3'd2) res_y_in = sat32(80'(m16));
               end
               OP_ROTATE: begin
                  unique case (ph_ff)
                     3'd0: mul_b = cx_ff;
                     3'd1: begin
                        acc_in = SW'(mul_ff);
                        mul_a  = vy_ff;
                        mul_b  = cy_ff;
                     end
                     3'd2: begin
                        acc_in = acc_ff - SW'(mul_ff);
                        mul_b  = cy_ff;
                     end
                     3'd3: begin
                        res_x_in = sat32(80'(r30));
                        acc_in   = SW'(mul_ff);
                        mul_a    = vy_ff;
                        mul_b    = cx_ff;
                     end
                     3'd4: acc_in = acc_ff + SW'(mul_ff);
                     3'd5: res_y_in = sat32(80'(r30));
                     default: begin
                     end
                  endcase
               end
               OP_DIVIDE: begin
                  unique case (ph_ff)
                     3'd0, 3'd2: div_start = 1'b1;
                     3'd1: begin
                        ph_in = ph_ff;
                        if (div_done) begin
                           res_x_in = div_res;
                           ph_in    = 3'd2;
                        end
                     end
                     3'd3: begin
                        ph_in = ph_ff;
                        if (div_done) res_y_in = div_res;
                     end
                     default: begin
                     end
                  endcase
               end
               OP_AREA: begin
                  unique case (ph_ff)
                     3'd0: mul_b = 34'(ny_ff);
                     3'd1: begin
                        acc_in = acc_ff + SW'(mul_ff);
                        mul_a  = vy_ff;
                        mul_b  = 34'(nx_ff);
                     end
                     3'd2: begin
                        acc_in = acc_ff - SW'(mul_ff);
                        vx_in  = nx_ff;
                        vy_in  = ny_ff;
                        if (!idx_last) begin
                           idx_in = AW'(32'(idx_ff) + 32'd1);
                           // The last edge closes back to the first vertex.
                           if (idx_next2_last) begin
                              nx_in = fx_ff;
                              ny_in = fy_ff;
                              ph_in = '0;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         S_WRITE: begin
            wr_en = 1'b1;
            if (!idx_last) idx_in = AW'(32'(idx_ff) + 32'd1);
         end
         S_ABS: mag_in = acc_ff[SW-1] ? SW'(-acc_ff) : SW'(acc_ff);
         S_ROUND: area_in = (|rsh[127:63]) ? {63{1'b1}} : rsh[62:0];
         S_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Response register.
   always_comb begin
      cnt_ext      = (CW + 7)'(count_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_area_in  = rsp_area_ff;
      rsp_count_in = rsp_count_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (state_ff == S_RESP && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = (op_ff == OP_READ && stat_ff == ST_OK) ? res_x_ff : 32'd0;
         rsp_y_in     = (op_ff == OP_READ && stat_ff == ST_OK) ? res_y_ff : 32'd0;
         rsp_area_in  = (op_ff == OP_AREA && stat_ff == ST_OK) ? area_ff : 63'd0;
         rsp_count_in = cnt_ext[6:0];
         rsp_stat_in  = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      stat_ff      <= stat_in;
      idx_ff       <= idx_in;
      ph_ff        <= ph_in;
      first_ok_ff  <= first_ok_in;
      flip_ff      <= flip_in;
      ci_ff        <= ci_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      f_ff         <= f_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      nx_ff        <= nx_in;
      ny_ff        <= ny_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      res_x_ff     <= res_x_in;
      res_y_ff     <= res_y_in;
      acc_ff       <= acc_in;
      mag_ff       <= mag_in;
      area_ff      <= area_in;
      mul_ff       <= mul_a * mul_b;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_area_ff  <= rsp_area_in;
      rsp_count_ff <= rsp_count_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   assign req_stall  = state_ff != S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = $signed(rsp_x_ff);
   assign rsp_out_y  = $signed(rsp_y_ff);
   assign rsp_area   = rsp_area_ff;
   assign rsp_count  = rsp_count_ff;
   assign rsp_status = rsp_stat_ff;

endmodule
`default_nettype wire

// ===== src/ptae_div.sv =====
`default_nettype none
module ptae_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [47:0]      quotient
);

   localparam int DW = 48;
   localparam int NW = $clog2(DW);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [32:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic [32:0]   rem_sh;
   logic          fits;

   // Restoring division, one quotient bit a cycle; the dividend shifts out
   // of the top of quo_ff while quotient bits shift in at the bottom.
   always_comb begin
      rem_sh  = {rem_ff[31:0], quo_ff[DW-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         quo_in = {quo_ff[DW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== src/ptae_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ptae_checker
   import ptae_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_out_x,
   input wire logic signed [31:0] rsp_out_y,
   input wire logic [62:0]        rsp_area,
   input wire logic [6:0]         rsp_count,
   input wire logic [1:0]         rsp_status
);

   // A rejected request carries no coordinates and no area.
   `ASSERT_IMPLY(a_reject_no_data, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0 && rsp_area == 63'd0)

   // An area result never comes with coordinates.
   `ASSERT_IMPLY(a_area_alone, clock, reset, rsp_valid && rsp_area != 63'd0, rsp_out_x == 32'sd0 && rsp_out_y == 32'sd0 && rsp_status == ST_OK)

   // An empty polygon is only reported with a vertex count of zero.
   `ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_count == 7'd0)

   // A stalled transfer holds its valid, area, count and status.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_area) && $stable(rsp_count) && $stable(rsp_status))

endmodule

bind polygon_transform_area_engine ptae_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_out_x  (rsp_out_x),
   .rsp_out_y  (rsp_out_y),
   .rsp_area   (rsp_area),
   .rsp_count  (rsp_count),
   .rsp_status (rsp_status)
);
`default_nettype wire
